// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the pool allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hdl/rrpa_pkg.sv -----
// Constants, codes and controller/datapath interface types of the pool allocator.
package rrpa_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int ID_W   = 16;
	localparam int ORD_W  = 16;
	localparam int SLOT_W = 4;
	localparam int OCC_W  = 5;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_ALLOC = 2'd1;
	localparam logic [1:0] OP_SET   = 2'd2;

	localparam logic [1:0] WS_AVAIL = 2'd0;
	localparam logic [1:0] WS_BUSY  = 2'd1;

	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_FULL       = 3'd1;
	localparam logic [2:0] ERR_EMPTY      = 3'd2;
	localparam logic [2:0] ERR_NONE_AVAIL = 3'd3;
	localparam logic [2:0] ERR_NOT_FOUND  = 3'd4;

	localparam logic signed [ORD_W-1:0] NO_ORDER = -16'sd1;

	typedef struct packed {
		logic accept;
		logic issue;
		logic resp_add;
		logic resp_hit;
		logic resp_miss;
		logic resp_other;
	} rrpa_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       empty;
		logic       valid;
		logic       hit;
		logic       last;
		logic       issued_all;
	} rrpa_sts_t;

endpackage

// ----- hdl/rrpa_ctrl.sv -----
// Controller state machine of the pool allocator: dispatch, scan and response sequencing.
`include "assert_macros.svh"

module rrpa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  rrpa_pkg::rrpa_sts_t sts,
	output rrpa_pkg::rrpa_cmd_t cmd,
	output logic               busy
);
	import rrpa_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       resp_any;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (sts.op)
					OP_ADD: begin
						cmd.resp_add = 1'b1;
						state_d      = S_IDLE;
					end
					OP_ALLOC, OP_SET: begin
						if (sts.empty) begin
							cmd.resp_miss = 1'b1;
							state_d       = S_IDLE;
						end else begin
							cmd.issue = 1'b1;
							state_d   = S_SCAN;
						end
					end
					default: begin
						cmd.resp_other = 1'b1;
						state_d        = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				// Reads run one entry ahead of the compare; a hit stops further reads.
				priority if (sts.hit) begin
					cmd.resp_hit = 1'b1;
					state_d      = S_IDLE;
				end else if (sts.valid && sts.last) begin
					cmd.resp_miss = 1'b1;
					state_d       = S_IDLE;
				end else if (!sts.issued_all) begin
					cmd.issue = 1'b1;
				end else begin
					state_d = S_SCAN;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign resp_any = cmd.resp_add | cmd.resp_hit | cmd.resp_miss | cmd.resp_other;

	`ASSERT_ALWAYS(a_resp_onehot,
		$onehot0({cmd.resp_add, cmd.resp_hit, cmd.resp_miss, cmd.resp_other}),
		"more than one response command in a cycle")
	`ASSERT_ALWAYS(a_issue_bound, cmd.issue |-> !sts.issued_all,
		"read issued beyond the filled entries")
	`ASSERT_NEXT(a_resp_idle, resp_any, state_q == S_IDLE,
		"controller not idle after a response")

endmodule

// ----- hdl/rrpa_datapath.sv -----
// Datapath of the pool allocator: entry memories, fill count, cursor, scan pointer, results.
`include "assert_macros.svh"

module rrpa_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rrpa_pkg::rrpa_cmd_t               cmd,
	output rrpa_pkg::rrpa_sts_t               sts,
	input  logic [1:0]                        operation,
	input  logic [rrpa_pkg::ID_W-1:0]         worker_id,
	input  logic [1:0]                        new_state,
	input  logic signed [rrpa_pkg::ORD_W-1:0] order_number,
	output logic                              done,
	output logic                              success,
	output logic [2:0]                        error_code,
	output logic [rrpa_pkg::SLOT_W-1:0]       slot_index,
	output logic [rrpa_pkg::ID_W-1:0]         granted_id,
	output logic signed [rrpa_pkg::ORD_W-1:0] granted_order,
	output logic [1:0]                        granted_state,
	output logic [rrpa_pkg::OCC_W-1:0]        occupancy,
	output logic                              pool_empty,
	output logic                              pool_full
);
	import rrpa_pkg::*;

	// Entry memories; an entry is read only after it was added.
	logic [ID_W-1:0]         id_mem  [CAPACITY];
	logic [1:0]              st_mem  [CAPACITY];
	logic signed [ORD_W-1:0] ord_mem [CAPACITY];

	logic [1:0]              op_q;
	logic [ID_W-1:0]         wid_q;
	logic [1:0]              nst_q;
	logic signed [ORD_W-1:0] ord_q;

	logic [CNT_W-1:0] fill_q;
	logic [IDX_W-1:0] cursor_q;
	logic [IDX_W-1:0] addr_q;
	logic [CNT_W-1:0] cnt_q;

	logic                    valid_s1;
	logic                    last_s1;
	logic [IDX_W-1:0]        addr_s1;
	logic [ID_W-1:0]         id_rd_s1;
	logic [1:0]              st_rd_s1;
	logic signed [ORD_W-1:0] ord_rd_s1;

	logic                    done_q;
	logic                    success_q;
	logic [2:0]              err_q;
	logic [IDX_W-1:0]        slot_q;
	logic [ID_W-1:0]         gid_q;
	logic signed [ORD_W-1:0] gord_q;
	logic [1:0]              gst_q;

	logic             full;
	logic             empty;
	logic             add_ok;
	logic             hit_s1;
	logic             resp_any;
	logic [IDX_W-1:0] fill_idx;
	logic [IDX_W-1:0] addr_nxt;
	logic [IDX_W-1:0] cursor_nxt;
	logic [CNT_W-1:0] cnt_inc;

	assign full     = (fill_q == CNT_W'(CAPACITY));
	assign empty    = (fill_q == '0);
	assign add_ok   = cmd.resp_add && !full;
	assign fill_idx = IDX_W'(fill_q);
	assign cnt_inc  = cnt_q + CNT_W'(1);
	assign resp_any = cmd.resp_add | cmd.resp_hit | cmd.resp_miss | cmd.resp_other;

	// Both pointers wrap at the fill count rather than at the capacity.
	assign addr_nxt   = ((CNT_W'(addr_q) + CNT_W'(1)) == fill_q) ? '0 : addr_q + IDX_W'(1);
	assign cursor_nxt = ((CNT_W'(addr_s1) + CNT_W'(1)) == fill_q) ? '0 : addr_s1 + IDX_W'(1);

	assign hit_s1 = valid_s1 && ((op_q == OP_ALLOC) ? (st_rd_s1 == WS_AVAIL)
	                                                : (id_rd_s1 == wid_q));

	always_ff @(posedge clk) begin
		if (add_ok) begin
			id_mem[fill_idx]  <= wid_q;
			st_mem[fill_idx]  <= nst_q;
			ord_mem[fill_idx] <= ord_q;
		end else if (cmd.resp_hit) begin
			if (op_q == OP_ALLOC) begin
				st_mem[addr_s1] <= WS_BUSY;
			end else begin
				st_mem[addr_s1] <= nst_q;
				if (nst_q == WS_AVAIL) begin
					ord_mem[addr_s1] <= NO_ORDER;
				end
			end
		end
		if (cmd.issue) begin
			id_rd_s1  <= id_mem[addr_q];
			st_rd_s1  <= st_mem[addr_q];
			ord_rd_s1 <= ord_mem[addr_q];
			addr_s1   <= addr_q;
			last_s1   <= (cnt_inc == fill_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= operation;
			wid_q <= worker_id;
			nst_q <= new_state;
			ord_q <= order_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			cursor_q <= '0;
			addr_q   <= '0;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			done_q   <= resp_any;
			if (add_ok) begin
				fill_q <= fill_q + CNT_W'(1);
			end
			if (cmd.resp_hit && (op_q == OP_ALLOC)) begin
				cursor_q <= cursor_nxt;
			end
			if (cmd.accept) begin
				addr_q <= (operation == OP_ALLOC) ? cursor_q : '0;
				cnt_q  <= '0;
			end else if (cmd.issue) begin
				addr_q <= addr_nxt;
				cnt_q  <= cnt_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (resp_any) begin
			priority if (cmd.resp_add) begin
				success_q <= !full;
				err_q     <= full ? ERR_FULL : ERR_NONE;
				slot_q    <= full ? '0 : fill_idx;
				gid_q     <= '0;
				gord_q    <= '0;
				gst_q     <= '0;
			end else if (cmd.resp_hit) begin
				success_q <= 1'b1;
				err_q     <= ERR_NONE;
				slot_q    <= addr_s1;
				gid_q     <= (op_q == OP_ALLOC) ? id_rd_s1 : '0;
				gord_q    <= (op_q == OP_ALLOC) ? ord_rd_s1 : '0;
				gst_q     <= (op_q == OP_ALLOC) ? WS_BUSY : '0;
			end else if (cmd.resp_miss) begin
				success_q <= 1'b0;
				err_q     <= (op_q == OP_ALLOC) ? (empty ? ERR_EMPTY : ERR_NONE_AVAIL)
				                                : ERR_NOT_FOUND;
				slot_q    <= '0;
				gid_q     <= '0;
				gord_q    <= '0;
				gst_q     <= '0;
			end else begin
				success_q <= 1'b0;
				err_q     <= ERR_NONE;
				slot_q    <= '0;
				gid_q     <= '0;
				gord_q    <= '0;
				gst_q     <= '0;
			end
		end
	end

	assign sts.op         = op_q;
	assign sts.empty      = empty;
	assign sts.valid      = valid_s1;
	assign sts.hit        = hit_s1;
	assign sts.last       = last_s1;
	assign sts.issued_all = (cnt_q == fill_q);

	assign done          = done_q;
	assign success       = success_q;
	assign error_code    = err_q;
	assign slot_index    = SLOT_W'(slot_q);
	assign granted_id    = gid_q;
	assign granted_order = gord_q;
	assign granted_state = gst_q;
	assign occupancy     = OCC_W'(fill_q);
	assign pool_empty    = empty;
	assign pool_full     = full;

	`ASSERT_ALWAYS(a_fill_bound, fill_q <= CNT_W'(CAPACITY),
		"fill count above capacity")
	`ASSERT_ALWAYS(a_cursor_range,
		(empty && (cursor_q == '0)) || (!empty && (CNT_W'(cursor_q) < fill_q)),
		"search cursor outside the filled entries")
	`ASSERT_ALWAYS(a_read_range, valid_s1 |-> (CNT_W'(addr_s1) < fill_q),
		"entry read beyond the fill count")

endmodule

// ----- hdl/round_robin_pool_allocator_unit.sv -----
// Top level of the round-robin pool allocator: controller and datapath.
//
// A command word (operation, worker_id, new_state, order_number) is taken at a
// rising edge where start is high and busy is low. Add appends an entry, allocate
// scans round-robin from the cursor for an available entry and marks it busy,
// set-state writes the state of the lowest slot whose id matches.
// Exactly one result word follows each command: done is high for one cycle and
// the result ports are valid in that cycle. The receiver cannot stall; the word
// is taken at the edge that ends the done cycle.
// Add, an unused operation code and a search on an empty pool respond from the
// decode state; any other search issues entry reads and responds at the first
// match or once the last filled entry is compared, examining at most occupancy
// entries. The scan reads one entry per cycle from the entry memory, its
// registered read overlapped with the compare of the entry before.
// busy falls together with the rise of done, so the next command can be taken in
// the done cycle. occupancy, pool_empty and pool_full show the state after the
// last command. Reset empties the pool and sets the cursor to slot zero; entry
// contents are not cleared.
module round_robin_pool_allocator_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        operation,
	input  logic [rrpa_pkg::ID_W-1:0]         worker_id,
	input  logic [1:0]                        new_state,
	input  logic signed [rrpa_pkg::ORD_W-1:0] order_number,
	output logic                              done,
	output logic                              success,
	output logic [2:0]                        error_code,
	output logic [rrpa_pkg::SLOT_W-1:0]       slot_index,
	output logic [rrpa_pkg::ID_W-1:0]         granted_id,
	output logic signed [rrpa_pkg::ORD_W-1:0] granted_order,
	output logic [1:0]                        granted_state,
	output logic [rrpa_pkg::OCC_W-1:0]        occupancy,
	output logic                              pool_empty,
	output logic                              pool_full
);
	import rrpa_pkg::*;

	rrpa_cmd_t cmd;
	rrpa_sts_t sts;

	rrpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	rrpa_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (operation),
		.worker_id     (worker_id),
		.new_state     (new_state),
		.order_number  (order_number),
		.done          (done),
		.success       (success),
		.error_code    (error_code),
		.slot_index    (slot_index),
		.granted_id    (granted_id),
		.granted_order (granted_order),
		.granted_state (granted_state),
		.occupancy     (occupancy),
		.pool_empty    (pool_empty),
		.pool_full     (pool_full)
	);

endmodule
